[src/csrmv_pkg.sv]
package csrmv_pkg;

  localparam int VECTOR_DEPTH  = 1024;
  localparam int VEC_AW        = $clog2(VECTOR_DEPTH);
  localparam int FRACTION_BITS = 16;
  localparam int ACC_W         = 48;
  localparam int PROD_W        = 64;
  localparam int SUM_W         = PROD_W + 1;
  localparam int CFG_AW        = 3;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_EMPTY   = 2'd2
  } op_t;

  // register index, taken from paddr[2]
  localparam logic REG_INDEX_BASE   = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  localparam logic [10:0] COLUMN_COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         x_index;
    logic signed [31:0] x_value;
    logic signed [31:0] matrix_value;
    logic [10:0]        column;
    logic               last_in_row;
  } item_t;

  typedef struct packed {
    logic [15:0]        row_index;
    logic signed [31:0] row_sum;
    logic               saturated;
    logic               bad_column;
  } result_t;

endpackage

[src/csr_sparse_matvec.sv]
// channel  | direction | handshake                 | payload
// item     | in        | item_valid / item_stall   | item (item_t)
// result   | out       | result_valid / result_stall | result (result_t)
// config   | in        | apb psel/penable/pwrite   | paddr, pwdata, prdata
//
// one item per cycle while item_stall is low; the beat that closes a row goes
// through the vector ram read, multiply, accumulate, then the clamp into the
// output register before the finished row shows on result.
// the vector ram read and the 32x32 multiply each own one stage.
// rst clears the pipeline, accumulator, flags, row counter and registers;
// vector ram contents stay undefined until loaded.
// a stalled result parks in a skid register; while it is full the whole
// pipeline holds and item_stall is high.
module csr_sparse_matvec
  import csrmv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic signed [SUM_W-1:0] ACC_MAX = (SUM_W'(1) <<< (ACC_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -(SUM_W'(1) <<< (ACC_W - 1));
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(33'sh0_7fff_ffff);
  localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(33'sh0_8000_0000);

  // configuration
  logic        index_base;
  logic [10:0] column_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_base   <= 1'b0;
      column_count <= COLUMN_COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_INDEX_BASE:   index_base   <= pwdata[0];
        REG_COLUMN_COUNT: column_count <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_INDEX_BASE:   prdata = {31'd0, index_base};
      REG_COLUMN_COUNT: prdata = {21'd0, column_count};
      default:          prdata = 32'd0;
    endcase
  end

  // pipeline control
  logic    skid_valid;
  result_t skid;
  logic    en;
  logic    accept;

  assign en         = !skid_valid;
  assign item_stall = skid_valid;
  assign accept     = item_valid && en;

  // stage 0: decode, range check, ram access
  logic              is_load;
  logic              is_nz;
  logic              is_empty;
  logic [10:0]       col_zb;
  logic              col_ok;
  logic              ram_we;
  logic              ram_re;
  logic [31:0]       ram_rdata;

  assign is_load  = item.opcode == OP_LOAD;
  assign is_nz    = item.opcode == OP_NONZERO;
  assign is_empty = item.opcode == OP_EMPTY;
  assign col_zb   = item.column - 11'(index_base);
  assign col_ok   = (item.column >= 11'(index_base)) && (col_zb < column_count)
                    && (32'(col_zb) < VECTOR_DEPTH);
  assign ram_we   = accept && is_load && (32'(item.x_index) < VECTOR_DEPTH);
  assign ram_re   = accept && is_nz && col_ok;

  csrmv_ram #(
    .WIDTH (32),
    .DEPTH (VECTOR_DEPTH)
  ) u_vector_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (VEC_AW'(item.x_index)),
    .wdata (item.x_value),
    .re    (ram_re),
    .raddr (VEC_AW'(col_zb)),
    .rdata (ram_rdata)
  );

  // stage 1: ram data ready, multiply
  logic               s1_valid;
  logic               s1_use;
  logic               s1_bad;
  logic               s1_finish;
  logic signed [31:0] s1_mval;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept && (is_nz || is_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_use    <= is_nz && col_ok;
      s1_bad    <= is_nz && !col_ok;
      s1_finish <= is_empty || item.last_in_row;
      s1_mval   <= item.matrix_value;
    end
  end

  // stage 2: product registered, accumulate
  logic                    s2_valid;
  logic                    s2_use;
  logic                    s2_bad;
  logic                    s2_finish;
  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_use    <= s1_use;
      s2_bad    <= s1_bad;
      s2_finish <= s1_finish;
      prod      <= s1_mval * signed'(ram_rdata);
    end
  end

  logic signed [ACC_W-1:0] acc;
  logic                    row_sat;
  logic                    row_bad;
  logic [15:0]             row_counter;
  logic signed [SUM_W-1:0] sum_wide;
  logic signed [ACC_W-1:0] acc_next;
  logic                    sat_next;
  logic                    bad_next;

  // floor shift of the product, then saturate to the accumulator range
  assign sum_wide = SUM_W'(acc) + SUM_W'(prod >>> FRACTION_BITS);

  always_comb begin
    acc_next = acc;
    sat_next = row_sat;
    bad_next = row_bad || s2_bad;
    if (s2_use) begin
      if (sum_wide > ACC_MAX) begin
        acc_next = ACC_W'(ACC_MAX);
        sat_next = 1'b1;
      end else if (sum_wide < ACC_MIN) begin
        acc_next = ACC_W'(ACC_MIN);
        sat_next = 1'b1;
      end else begin
        acc_next = ACC_W'(sum_wide);
      end
    end
  end

  // stage 3: finished row waits for the 32-bit clamp
  logic                    res_valid;
  logic signed [ACC_W-1:0] res_acc;
  logic                    res_sat;
  logic                    res_bad;
  logic [15:0]             res_row;
  logic                    row_done;

  assign row_done = en && s2_valid && s2_finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      row_sat     <= 1'b0;
      row_bad     <= 1'b0;
      row_counter <= '0;
      res_valid   <= 1'b0;
    end else if (en) begin
      res_valid <= row_done;
      if (s2_valid) begin
        if (s2_finish) begin
          acc         <= '0;
          row_sat     <= 1'b0;
          row_bad     <= 1'b0;
          row_counter <= row_counter + 16'd1;
        end else begin
          acc     <= acc_next;
          row_sat <= sat_next;
          row_bad <= bad_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_done) begin
      res_acc <= acc_next;
      res_sat <= sat_next;
      res_bad <= bad_next;
      res_row <= row_counter;
    end
  end

  result_t cand;

  always_comb begin
    cand.row_index  = res_row;
    cand.bad_column = res_bad;
    cand.saturated  = res_sat;
    cand.row_sum    = 32'(res_acc);
    if (res_acc > OUT_MAX) begin
      cand.row_sum   = 32'(OUT_MAX);
      cand.saturated = 1'b1;
    end else if (res_acc < OUT_MIN) begin
      cand.row_sum   = 32'(OUT_MIN);
      cand.saturated = 1'b1;
    end
  end

  // output register with skid behind it
  logic push;
  logic pop;

  assign push = en && res_valid;
  assign pop  = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (result_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        result <= skid;
      end
    end else if (push) begin
      if (result_valid && !pop) begin
        skid <= cand;
      end else begin
        result <= cand;
      end
    end
  end

  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a beat with no result in front of it");

  a_skid_holds_input: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> item_stall && !ram_we && !ram_re)
    else $error("ram touched while pipeline is held");

  a_row_clears: assert property (@(posedge clk) disable iff (rst)
    row_done |=> acc == '0 && !row_sat && !row_bad && res_valid)
    else $error("row state not cleared after finish");

  a_counter_steps: assert property (@(posedge clk) disable iff (rst)
    row_done |=> row_counter == $past(row_counter) + 16'd1)
    else $error("row counter did not advance on finish");

endmodule

[src/csrmv_ram.sv]
module csrmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
